### rtl/rebed_pkg.sv
// Shared types and constants for the rotary encoder and button event decoder.
`timescale 1ns / 1ps
`default_nettype none
package rebed_pkg;

  localparam int CNT_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SECOND     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_THRESHOLD = 2'd1;

  localparam logic [CNT_W-1:0] TICKS_PER_SECOND_RESET     = 16'd250;
  localparam logic [CNT_W-1:0] LONG_PRESS_THRESHOLD_RESET = 16'd249;
  localparam logic [CNT_W-1:0] TIMER_MAX                  = 16'hFFFF;

  localparam logic [1:0] ENC_DETENT     = 2'b11;
  localparam logic [1:0] ENC_FROM_LEFT  = 2'b10;
  localparam logic [1:0] ENC_FROM_RIGHT = 2'b01;
  localparam logic [1:0] ENC_IDLE       = 2'b00;

  typedef struct packed {
    logic pressed;
    logic released_short;
    logic released_long;
  } btn_evt_t;

  typedef struct packed {
    logic turned;
    logic step_right;
    logic step_left;
  } enc_evt_t;

endpackage
`default_nettype wire

### rtl/rebed_tick_div.sv
// Tick divider that flags the last tick of each configured period.
`timescale 1ns / 1ps
`default_nettype none
module rebed_tick_div
  import rebed_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             tick,
  input  wire logic [CNT_W-1:0] period,
  output logic                  second_tick
);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [CNT_W:0]   count_inc;

  always_comb begin
    count_inc   = {1'b0, count_r} + {{CNT_W{1'b0}}, 1'b1};
    second_tick = (count_inc >= {1'b0, period});
    count_nxt   = second_tick ? '0 : count_inc[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (tick) begin
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/rebed_button.sv
// Button edge detection and short or long press classification.
`timescale 1ns / 1ps
`default_nettype none
module rebed_button
  import rebed_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             tick,
  input  wire logic             pin_button,
  input  wire logic [CNT_W-1:0] threshold,
  output btn_evt_t              evt
);

  logic             last_r;
  logic [CNT_W-1:0] timer_r;
  logic [CNT_W-1:0] timer_nxt;
  logic             rise;
  logic             fall;

  always_comb begin
    rise      = pin_button & ~last_r;
    fall      = ~pin_button & last_r;
    timer_nxt = timer_r;
    if (rise) begin
      timer_nxt = '0;
    end else if (timer_r != TIMER_MAX) begin
      timer_nxt = timer_r + {{(CNT_W-1){1'b0}}, 1'b1};
    end
    evt.pressed        = rise;
    evt.released_long  = fall & (timer_nxt > threshold);
    evt.released_short = fall & ~(timer_nxt > threshold);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r  <= 1'b0;
      timer_r <= '0;
    end else if (tick) begin
      last_r  <= pin_button;
      timer_r <= timer_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/rebed_detent.sv
// Quadrature detent decoder with arming on the idle state.
`timescale 1ns / 1ps
`default_nettype none
module rebed_detent
  import rebed_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic tick,
  input  wire logic pin_a,
  input  wire logic pin_b,
  output enc_evt_t  evt
);

  logic [1:0] last_r;
  logic       armed_r;
  logic       armed_nxt;
  logic [1:0] enc;
  logic       hit;

  always_comb begin
    enc            = {pin_b, pin_a};
    hit            = armed_r & (enc == ENC_DETENT);
    evt.turned     = hit;
    evt.step_left  = hit & (last_r == ENC_FROM_LEFT);
    evt.step_right = hit & (last_r == ENC_FROM_RIGHT);
    armed_nxt      = hit ? 1'b0 : armed_r;
    if (enc == ENC_IDLE) begin
      armed_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r  <= ENC_IDLE;
      armed_r <= 1'b0;
    end else if (tick) begin
      last_r  <= enc;
      armed_r <= armed_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/rotary_encoder_button_event_decoder_core.sv
// Top level: config registers, decoder units and the result register.
// Timing: the result item is registered in the cycle after its tick item is accepted.
// Throughput: one item per cycle; the single result register stalls input
// only while it holds an item that the output side has not taken.
// Reset: synchronous active-low rst_n clears all counters, edge and arming
// state and the result valid; registers return to 250 and 249.
`timescale 1ns / 1ps
`default_nettype none
module rotary_encoder_button_event_decoder_core
  import rebed_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_pin_a,
  input  wire logic                 in_pin_b,
  input  wire logic                 in_pin_button,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_second_tick,
  output logic                      out_turned,
  output logic                      out_step_right,
  output logic                      out_step_left,
  output logic                      out_pressed,
  output logic                      out_released_short,
  output logic                      out_released_long
);

  logic [CNT_W-1:0] tps_r;
  logic [CNT_W-1:0] lpt_r;
  logic             tick;
  logic             sec;
  btn_evt_t         btn_evt;
  enc_evt_t         enc_evt;
  logic             out_valid_r;
  logic             sec_r;
  btn_evt_t         btn_evt_r;
  enc_evt_t         enc_evt_r;

  assign in_stall = out_valid_r & out_stall;
  assign tick     = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r <= TICKS_PER_SECOND_RESET;
      lpt_r <= LONG_PRESS_THRESHOLD_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_TICKS_PER_SECOND) begin
        tps_r <= cfg_wdata[CNT_W-1:0];
      end
      if (cfg_index == CFG_LONG_PRESS_THRESHOLD) begin
        lpt_r <= cfg_wdata[CNT_W-1:0];
      end
    end
  end

  rebed_tick_div u_tick_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick        (tick),
    .period      (tps_r),
    .second_tick (sec)
  );

  rebed_button u_button (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick       (tick),
    .pin_button (in_pin_button),
    .threshold  (lpt_r),
    .evt        (btn_evt)
  );

  rebed_detent u_detent (
    .clk   (clk),
    .rst_n (rst_n),
    .tick  (tick),
    .pin_a (in_pin_a),
    .pin_b (in_pin_b),
    .evt   (enc_evt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (tick) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      sec_r     <= sec;
      btn_evt_r <= btn_evt;
      enc_evt_r <= enc_evt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_second_tick    = sec_r;
  assign out_turned         = enc_evt_r.turned;
  assign out_step_right     = enc_evt_r.step_right;
  assign out_step_left      = enc_evt_r.step_left;
  assign out_pressed        = btn_evt_r.pressed;
  assign out_released_short = btn_evt_r.released_short;
  assign out_released_long  = btn_evt_r.released_long;

endmodule
`default_nettype wire

### dv/rebed_event_checker.sv
// Checker for the encoder and button event decoder: predicts each result item and compares.
`timescale 1ns / 1ps
module rebed_event_checker
  import rebed_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_wdata,
  input  wire logic                 in_valid,
  input  wire logic                 in_stall,
  input  wire logic                 in_pin_a,
  input  wire logic                 in_pin_b,
  input  wire logic                 in_pin_button,
  input  wire logic                 out_valid,
  input  wire logic                 out_stall,
  input  wire logic                 out_second_tick,
  input  wire logic                 out_turned,
  input  wire logic                 out_step_right,
  input  wire logic                 out_step_left,
  input  wire logic                 out_pressed,
  input  wire logic                 out_released_short,
  input  wire logic                 out_released_long,
  output int                        mismatch_count,
  output int                        flags_pending
);

  typedef struct packed {
    logic second_tick;
    logic turned;
    logic step_right;
    logic step_left;
    logic pressed;
    logic released_short;
    logic released_long;
  } tick_flags_t;

  logic [CNT_W-1:0] ticks_per_sec;
  logic [CNT_W-1:0] long_thresh;
  logic [CNT_W-1:0] period_cnt;
  logic [CNT_W-1:0] press_tmr;
  logic             btn_q;
  logic [1:0]       enc_q;
  logic             armed_q;

  tick_flags_t flags_expected [$];
  int          errs = 0;
  int          shown = 0;
  int          results_seen = 0;

  task automatic predict_tick(input logic pa, input logic pb, input logic pbtn,
                              output tick_flags_t f);
    logic [1:0]     enc;
    logic [CNT_W:0] next_cnt;
    f = '0;
    enc = {pb, pa};
    next_cnt = {1'b0, period_cnt} + 1'b1;
    if (next_cnt >= {1'b0, ticks_per_sec}) begin
      period_cnt = '0;
      f.second_tick = 1'b1;
    end else begin
      period_cnt = next_cnt[CNT_W-1:0];
    end
    if (pbtn && !btn_q) begin
      f.pressed = 1'b1;
      press_tmr = '0;
    end else begin
      if (press_tmr != TIMER_MAX) press_tmr = press_tmr + 1'b1;
      if (!pbtn && btn_q) begin
        if (press_tmr > long_thresh) f.released_long = 1'b1;
        else f.released_short = 1'b1;
      end
    end
    btn_q = pbtn;
    if (armed_q && enc == ENC_DETENT) begin
      f.step_left  = (enc_q == ENC_FROM_LEFT);
      f.step_right = (enc_q == ENC_FROM_RIGHT);
      f.turned     = 1'b1;
      armed_q      = 1'b0;
    end
    if (enc == ENC_IDLE) armed_q = 1'b1;
    enc_q = enc;
  endtask

  task automatic check_field(input string label, input logic want_bit, input logic got_bit);
    if (got_bit !== want_bit) begin
      errs++;
      if (shown < 10) begin
        shown++;
        $display("checker: result %0d %s expected %0b got %0b",
                 results_seen, label, want_bit, got_bit);
      end
    end
  endtask

  always @(posedge clk) begin
    tick_flags_t want;
    if (!rst_n) begin
      ticks_per_sec = TICKS_PER_SECOND_RESET;
      long_thresh   = LONG_PRESS_THRESHOLD_RESET;
      period_cnt    = '0;
      press_tmr     = '0;
      btn_q         = 1'b0;
      enc_q         = ENC_IDLE;
      armed_q       = 1'b0;
      flags_expected.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_TICKS_PER_SECOND) ticks_per_sec = cfg_wdata;
        else if (cfg_index == CFG_LONG_PRESS_THRESHOLD) long_thresh = cfg_wdata;
      end
      if (out_valid && !out_stall) begin
        if (flags_expected.size() == 0) begin
          errs++;
          if (shown < 10) begin
            shown++;
            $display("checker: result %0d arrived with nothing expected", results_seen);
          end
        end else begin
          want = flags_expected.pop_front();
          check_field("second_tick", want.second_tick, out_second_tick);
          check_field("turned", want.turned, out_turned);
          check_field("step_right", want.step_right, out_step_right);
          check_field("step_left", want.step_left, out_step_left);
          check_field("pressed", want.pressed, out_pressed);
          check_field("released_short", want.released_short, out_released_short);
          check_field("released_long", want.released_long, out_released_long);
        end
        results_seen++;
      end
      if (in_valid && !in_stall) begin
        predict_tick(in_pin_a, in_pin_b, in_pin_button, want);
        flags_expected.push_back(want);
      end
    end
    mismatch_count <= errs;
    flags_pending  <= flags_expected.size();
  end

endmodule

### dv/tb.sv
// Testbench top: clock, reset, stimulus, stall patterns and the verdict.
`timescale 1ns / 1ps
module tb;
  import rebed_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
  localparam int QUIET_LIMIT = 4000;

  typedef enum int {RX_FREE, RX_SPARSE, RX_PERIODIC, RX_HEAVY, RX_HOLD} rx_mode_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_pin_a;
  logic                 in_pin_b;
  logic                 in_pin_button;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_second_tick;
  logic                 out_turned;
  logic                 out_step_right;
  logic                 out_step_left;
  logic                 out_pressed;
  logic                 out_released_short;
  logic                 out_released_long;
  int                   mismatch_count;
  int                   flags_pending;

  logic [1:0] gray_seq [4] = '{ENC_IDLE, ENC_FROM_RIGHT, ENC_DETENT, ENC_FROM_LEFT};
  int         gray_pos = 0;
  int         turn_dir = 1;
  logic       btn_lvl = 1'b0;
  int         btn_run = 0;
  int         burst_left = 0;
  int         quiet_cycles = 0;

  always #4 clk = ~clk;

  rotary_encoder_button_event_decoder_core i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_pin_a           (in_pin_a),
    .in_pin_b           (in_pin_b),
    .in_pin_button      (in_pin_button),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_second_tick    (out_second_tick),
    .out_turned         (out_turned),
    .out_step_right     (out_step_right),
    .out_step_left      (out_step_left),
    .out_pressed        (out_pressed),
    .out_released_short (out_released_short),
    .out_released_long  (out_released_long)
  );

  rebed_event_checker i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_pin_a           (in_pin_a),
    .in_pin_b           (in_pin_b),
    .in_pin_button      (in_pin_button),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_second_tick    (out_second_tick),
    .out_turned         (out_turned),
    .out_step_right     (out_step_right),
    .out_step_left      (out_step_left),
    .out_pressed        (out_pressed),
    .out_released_short (out_released_short),
    .out_released_long  (out_released_long),
    .mismatch_count     (mismatch_count),
    .flags_pending      (flags_pending)
  );

  // offer one tick item, hold it until taken, then maybe open a gap
  task automatic offer(input logic a, input logic b, input logic btn);
    in_valid      <= 1'b1;
    in_pin_a      <= a;
    in_pin_b      <= b;
    in_pin_button <= btn;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(0, 12);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (flags_pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // quadrature walk with occasional glitches; button held for random runs
  task automatic random_ticks(input int n, input int hold_max);
    int         k;
    int         r;
    logic [1:0] enc;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 19);
      if (r < 2) begin
        gray_pos = $urandom_range(0, 3);
      end else if (r >= 4) begin
        if (r < 6) turn_dir = 4 - turn_dir;
        gray_pos = (gray_pos + turn_dir) % 4;
      end
      enc = gray_seq[gray_pos];
      if (btn_run == 0) begin
        btn_lvl = ~btn_lvl;
        btn_run = btn_lvl ? $urandom_range(1, hold_max) : $urandom_range(1, 8);
      end
      btn_run--;
      offer(enc[0], enc[1], btn_lvl);
    end
  endtask

  task automatic run_phase(input logic [CFG_DAT_W-1:0] tps, input logic [CFG_DAT_W-1:0] thr,
                           input int n, input int hold_max);
    settle();
    write_reg(CFG_TICKS_PER_SECOND, tps);
    write_reg(CFG_LONG_PRESS_THRESHOLD, thr);
    random_ticks(n, hold_max);
  endtask

  // receiver: segments of free, sparse, periodic, heavy and long hold-off stalling
  initial begin
    rx_mode_t mode;
    int       seg_len;
    int       k;
    out_stall <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    // long hold-off while the sender keeps offering
    out_stall <= 1'b1;
    repeat (120) @(posedge clk);
    out_stall <= 1'b0;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 4));
      seg_len = (mode == RX_HOLD) ? 140 : $urandom_range(16, 200);
      for (k = 0; k < seg_len; k++) begin
        case (mode)
          RX_FREE:     out_stall <= 1'b0;
          RX_SPARSE:   out_stall <= ($urandom_range(0, 9) < 3);
          RX_PERIODIC: out_stall <= (k % 3 == 2);
          RX_HEAVY:    out_stall <= ($urandom_range(0, 9) < 7);
          default:     out_stall <= (k < 120);
        endcase
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    int n;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_TICKS_PER_SECOND;
    cfg_wdata     <= '0;
    in_valid      <= 1'b0;
    in_pin_a      <= 1'b0;
    in_pin_b      <= 1'b0;
    in_pin_button <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // detent right after reset is not armed
    offer(1'b1, 1'b1, 1'b0);
    offer(1'b0, 1'b0, 1'b1);
    offer(1'b0, 1'b1, 1'b1);
    offer(1'b1, 1'b1, 1'b1);
    offer(1'b1, 1'b1, 1'b0);
    offer(1'b0, 1'b0, 1'b0);
    offer(1'b1, 1'b0, 1'b0);
    offer(1'b1, 1'b1, 1'b1);
    offer(1'b1, 1'b1, 1'b1);
    offer(1'b0, 1'b0, 1'b1);
    offer(1'b1, 1'b1, 1'b0);
    offer(1'b0, 1'b0, 1'b0);
    offer(1'b1, 1'b1, 1'b0);
    offer(1'b0, 1'b1, 1'b0);
    offer(1'b1, 1'b0, 1'b0);
    offer(1'b1, 1'b1, 1'b0);
    random_ticks(70, 300);

    run_phase(16'd1, 16'd0, 150, 6);
    run_phase(16'd0, 16'd3, 150, 10);
    for (n = 0; n < 3; n++)
      run_phase(CFG_DAT_W'($urandom_range(1, 20)), CFG_DAT_W'($urandom_range(0, 30)), 200, 64);

    // writes to unused indexes must leave both registers alone
    settle();
    write_reg(CFG_SPARE_LO, 16'h0001);
    write_reg(CFG_SPARE_HI, 16'hFFFF);
    random_ticks(120, 20);

    run_phase(16'hFFFF, 16'hFFFF, 100, 40);
    run_phase(CFG_DAT_W'($urandom_range(0, 65535)), CFG_DAT_W'($urandom_range(0, 65535)),
              150, 64);
    run_phase(16'd3, 16'd20, 200, 50);

    settle();
    if (mismatch_count == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule
